// ===== hdl/rau_pkg.sv =====
package rau_pkg;

   localparam int WORD_BITS = 64;
   localparam int DEN_BITS  = WORD_BITS - 1;
   localparam int CNT_BITS  = 6;

   localparam logic [WORD_BITS-1:0] VMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [WORD_BITS-1:0] VMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   // Last step index of a multiply (one step per magnitude bit) and a divide.
   localparam logic [CNT_BITS-1:0] MUL_LAST = CNT_BITS'(WORD_BITS - 2);
   localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(WORD_BITS - 1);

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_CMP = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ORD_LESS    = 2'd0,
      ORD_EQUAL   = 2'd1,
      ORD_GREATER = 2'd2
   } order_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_ZERO_DEN = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      STEP_HOLD,
      STEP_MUL,
      STEP_DIV,
      STEP_GCD
   } step_mode_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD,
      S_MUL,
      S_COMB,
      S_RED,
      S_GCD,
      S_DIV,
      S_DVEND,
      S_DONE
   } state_type;

   // Working registers handed to the shared step unit
   typedef struct packed {
      logic [WORD_BITS-1:0] x;
      logic [WORD_BITS-1:0] y;
      logic [WORD_BITS-1:0] acc;
   } work_type;

   // Side results of one step
   typedef struct packed {
      logic ovf_hit;
      logic k_inc;
   } step_flags_type;

   function automatic logic [WORD_BITS-1:0] mag(input logic [WORD_BITS-1:0] v);
      mag = v[WORD_BITS-1] ? (~v + 1'b1) : v;
   endfunction

endpackage

// ===== hdl/rau_req_if.sv =====
interface rau_req_if;
   logic                              valid;
   logic                              ready;
   logic [2:0]                        op;
   logic signed [rau_pkg::WORD_BITS-1:0] a_num;
   logic [rau_pkg::DEN_BITS-1:0]      a_den;
   logic signed [rau_pkg::WORD_BITS-1:0] b_num;
   logic [rau_pkg::DEN_BITS-1:0]      b_den;

   modport source (output valid, op, a_num, a_den, b_num, b_den, input ready);
   modport sink   (input valid, op, a_num, a_den, b_num, b_den, output ready);
endinterface

// ===== hdl/rau_rsp_if.sv =====
interface rau_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [rau_pkg::WORD_BITS-1:0] res_num;
   logic [rau_pkg::DEN_BITS-1:0]      res_den;
   logic [1:0]                        order;
   logic [1:0]                        status;

   modport source (output valid, res_num, res_den, order, status, input ready);
   modport sink   (input valid, res_num, res_den, order, status, output ready);
endinterface

// ===== hdl/rau_step.sv =====
// Shared step unit: one multiply, divide or gcd step per cycle.
module rau_step (
   input  rau_pkg::step_mode_type  mode,
   input  rau_pkg::work_type       cur,
   output rau_pkg::work_type       nxt,
   output rau_pkg::step_flags_type flags
);
   import rau_pkg::*;

   logic [WORD_BITS+1:0] mul_t;
   logic [WORD_BITS+1:0] div_r;
   logic [WORD_BITS+1:0] div_d;
   logic [WORD_BITS:0]   gcd_d;

   always_comb begin
      nxt   = cur;
      flags = '0;
      mul_t = '0;
      div_r = '0;
      div_d = '0;
      gcd_d = '0;
      case (mode)
         STEP_MUL: begin
            // shift-add, multiplier MSB first; overflow is sticky outside
            mul_t = {1'b0, cur.acc, 1'b0} +
                    (cur.y[WORD_BITS-2] ? {2'b00, cur.x} : '0);
            flags.ovf_hit = (mul_t > {2'b00, VMAX});
            nxt.acc = mul_t[WORD_BITS-1:0];
            nxt.y   = {cur.y[WORD_BITS-2:0], 1'b0};
         end
         STEP_DIV: begin
            // restoring division, quotient bits shift into y
            div_r = {1'b0, cur.acc, cur.y[WORD_BITS-1]};
            div_d = div_r - {2'b00, cur.x};
            nxt.acc = div_d[WORD_BITS+1] ? div_r[WORD_BITS-1:0] : div_d[WORD_BITS-1:0];
            nxt.y   = {cur.y[WORD_BITS-2:0], ~div_d[WORD_BITS+1]};
         end
         STEP_GCD: begin
            // binary gcd step
            gcd_d = {1'b0, cur.x} - {1'b0, cur.y};
            if (cur.x != '0) begin
               if (!cur.x[0] && !cur.y[0]) begin
                  nxt.x = cur.x >> 1;
                  nxt.y = cur.y >> 1;
                  flags.k_inc = 1'b1;
               end else if (!cur.x[0]) begin
                  nxt.x = cur.x >> 1;
               end else if (!cur.y[0]) begin
                  nxt.y = cur.y >> 1;
               end else if (!gcd_d[WORD_BITS]) begin
                  nxt.x = gcd_d[WORD_BITS-1:0];
               end else begin
                  nxt.y = ~gcd_d[WORD_BITS-1:0] + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== hdl/rational_arith_unit.sv =====
// Channel | Dir | Fields
// req_if  | in  | op, a_num, a_den, b_num, b_den
// rsp_if  | out | res_num, res_den, order, status
//
// One item at a time; req_if.ready is high only when the unit is idle.
// Each checked product runs on the shared shift-add unit (two or three per
// item), followed by the binary gcd and the two divisions by the gcd; a
// compare ends after its two products. Early errors go straight from idle
// to the result. Synchronous active-high reset clears control.
// A result holds on rsp_if until taken.
module rational_arith_unit (
   input logic      clock,
   input logic      reset,
   rau_req_if.sink  req_if,
   rau_rsp_if.source rsp_if
);
   import rau_pkg::*;

   state_type             state_ff, state_in;
   logic [2:0]            op_ff, op_in;
   logic [WORD_BITS-1:0]  an_ff, an_in, bn_ff, bn_in;
   logic [DEN_BITS-1:0]   ad_ff, ad_in, bd_ff, bd_in;
   logic [1:0]            slot_ff, slot_in;
   logic                  neg_ff, neg_in;
   logic                  ovf_ff, ovf_in;
   logic                  dph_ff, dph_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [CNT_BITS-1:0]   k_ff, k_in;
   logic [WORD_BITS-1:0]  p_ff, p_in, q_ff, q_in;
   work_type              work_ff, work_in, work_nx;
   step_mode_type         mode;
   step_flags_type        flags;
   logic [WORD_BITS-1:0]  rnum_ff, rnum_in;
   logic [DEN_BITS-1:0]   rden_ff, rden_in;
   logic [1:0]            rord_ff, rord_in;
   logic [1:0]            rst_ff, rst_in;

   logic [WORD_BITS-1:0]  sa, sb, prod;
   logic [WORD_BITS:0]    sum;
   logic                  sum_ovf, early;
   logic [2:0]            early_st;

   rau_step u_step (
      .mode  (mode),
      .cur   (work_ff),
      .nxt   (work_nx),
      .flags (flags)
   );

   // operand pair for the current product slot
   always_comb begin
      sa = an_ff;
      sb = {1'b0, bd_ff};
      case (slot_ff)
         2'd0: begin
            sa = an_ff;
            sb = (op_ff == OP_MUL) ? bn_ff : {1'b0, bd_ff};
         end
         2'd1: begin
            sa = {1'b0, ad_ff};
            sb = (op_ff == OP_MUL) ? {1'b0, bd_ff} : bn_ff;
         end
         default: begin
            sa = {1'b0, ad_ff};
            sb = {1'b0, bd_ff};
         end
      endcase
   end

   // signed product and the add/subtract combine
   always_comb begin
      prod = neg_ff ? (~work_ff.acc + 1'b1) : work_ff.acc;
      if (op_ff == OP_SUB)
         sum = {p_ff[WORD_BITS-1], p_ff} - {prod[WORD_BITS-1], prod};
      else
         sum = {p_ff[WORD_BITS-1], p_ff} + {prod[WORD_BITS-1], prod};
      sum_ovf = sum[WORD_BITS] != sum[WORD_BITS-1];
   end

   // checks made on the incoming item
   always_comb begin
      early    = 1'b1;
      early_st = 3'd0;
      if (req_if.op > OP_CMP)
         early_st = 3'd1;
      else if (req_if.a_den == '0 || req_if.b_den == '0)
         early_st = 3'd2;
      else if (req_if.a_num == VMIN || req_if.b_num == VMIN)
         early_st = 3'd3;
      else
         early = 1'b0;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_if.valid) state_in = early ? S_DONE : S_LOAD;
         S_LOAD:  state_in = S_MUL;
         S_MUL:   if (cnt_ff == MUL_LAST) state_in = S_COMB;
         S_COMB: begin
            if (ovf_ff)
               state_in = S_DONE;
            else if (slot_ff == 2'd0)
               state_in = S_LOAD;
            else if (slot_ff == 2'd1) begin
               if (op_ff == OP_ADD || op_ff == OP_SUB)
                  state_in = sum_ovf ? S_DONE : S_LOAD;
               else if (op_ff == OP_CMP)
                  state_in = S_DONE;
               else
                  state_in = S_RED;
            end else
               state_in = S_RED;
         end
         S_RED:   state_in = (q_ff == '0) ? S_DONE : S_GCD;
         S_GCD:   if (work_ff.x == '0) state_in = S_DIV;
         S_DIV:   if (cnt_ff == DIV_LAST) state_in = S_DVEND;
         S_DVEND: state_in = dph_ff ? S_DONE : S_DIV;
         S_DONE:  if (rsp_if.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      op_in = op_ff; an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      slot_in = slot_ff; neg_in = neg_ff; ovf_in = ovf_ff; dph_in = dph_ff;
      cnt_in = cnt_ff; k_in = k_ff; p_in = p_ff; q_in = q_ff;
      work_in = work_ff; mode = STEP_HOLD;
      rnum_in = rnum_ff; rden_in = rden_ff; rord_in = rord_ff; rst_in = rst_ff;
      case (state_ff)
         S_IDLE: begin
            op_in = req_if.op; an_in = req_if.a_num; ad_in = req_if.a_den;
            bn_in = req_if.b_num; bd_in = req_if.b_den;
            slot_in = 2'd0; ovf_in = 1'b0;
            rnum_in = '0; rden_in = '0; rord_in = ORD_EQUAL;
            case (early_st)
               3'd1: begin rden_in = DEN_BITS'(1); rst_in = ST_OK; end
               3'd2: rst_in = ST_ZERO_DEN;
               default: rst_in = ST_OVERFLOW;
            endcase
         end
         S_LOAD: begin
            work_in.x   = mag(sa);
            work_in.y   = mag(sb);
            work_in.acc = '0;
            cnt_in = '0;
            neg_in = sa[WORD_BITS-1] ^ sb[WORD_BITS-1];
         end
         S_MUL: begin
            mode    = STEP_MUL;
            work_in = work_nx;
            ovf_in  = ovf_ff | flags.ovf_hit;
            cnt_in  = cnt_ff + 1'b1;
         end
         S_COMB: begin
            slot_in = slot_ff + 1'b1;
            rnum_in = '0; rden_in = '0; rord_in = ORD_EQUAL; rst_in = ST_OVERFLOW;
            if (slot_ff == 2'd0)
               p_in = prod;
            else if (slot_ff == 2'd1) begin
               if (op_ff == OP_ADD || op_ff == OP_SUB)
                  p_in = sum[WORD_BITS-1:0];
               else if (op_ff == OP_CMP) begin
                  rst_in = ST_OK;
                  if ($signed(p_ff) < $signed(prod))
                     rord_in = ORD_LESS;
                  else if (p_ff != prod)
                     rord_in = ORD_GREATER;
               end else
                  q_in = prod;
            end else
               q_in = prod;
            // an overflowed product always ends the item with overflow
            if (ovf_ff) begin
               rord_in = ORD_EQUAL;
               rst_in  = ST_OVERFLOW;
            end
         end
         S_RED: begin
            rnum_in = '0; rden_in = '0; rord_in = ORD_EQUAL; rst_in = ST_ZERO_DEN;
            neg_in  = p_ff[WORD_BITS-1] ^ q_ff[WORD_BITS-1];
            p_in    = mag(p_ff);
            q_in    = mag(q_ff);
            work_in.x = mag(p_ff);
            work_in.y = mag(q_ff);
            k_in = '0;
         end
         S_GCD: begin
            if (work_ff.x == '0) begin
               work_in.x   = work_ff.y << k_ff;
               work_in.y   = p_ff;
               work_in.acc = '0;
               cnt_in = '0;
               dph_in = 1'b0;
            end else begin
               mode    = STEP_GCD;
               work_in = work_nx;
               k_in    = k_ff + CNT_BITS'(flags.k_inc);
            end
         end
         S_DIV: begin
            mode    = STEP_DIV;
            work_in = work_nx;
            cnt_in  = cnt_ff + 1'b1;
         end
         S_DVEND: begin
            if (!dph_ff) begin
               p_in = work_ff.y;
               work_in.y   = q_ff;
               work_in.acc = '0;
               cnt_in = '0;
               dph_in = 1'b1;
            end else begin
               rord_in = ORD_EQUAL;
               if (p_ff[WORD_BITS-1] || work_ff.y[WORD_BITS-1]) begin
                  rnum_in = '0; rden_in = '0; rst_in = ST_OVERFLOW;
               end else begin
                  rnum_in = (neg_ff && p_ff != '0) ? (~p_ff + 1'b1) : p_ff;
                  rden_in = work_ff.y[DEN_BITS-1:0];
                  rst_in  = ST_OK;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // handshake outputs
   always_comb begin
      req_if.ready   = (state_ff == S_IDLE);
      rsp_if.valid   = (state_ff == S_DONE);
      rsp_if.res_num = rnum_ff;
      rsp_if.res_den = rden_ff;
      rsp_if.order   = rord_ff;
      rsp_if.status  = rst_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff <= op_in; an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      slot_ff <= slot_in; neg_ff <= neg_in; ovf_ff <= ovf_in; dph_ff <= dph_in;
      cnt_ff <= cnt_in; k_ff <= k_in; p_ff <= p_in; q_ff <= q_in;
      work_ff <= work_in;
      rnum_ff <= rnum_in; rden_ff <= rden_in; rord_ff <= rord_in; rst_ff <= rst_in;
   end

endmodule
